/* rtl/skte_pkg.sv */
// ----------------------------------------------------------------------------
// skte_pkg: shared types and constants for the scan-code key event tracker
// Operation codes, scan-code constants and the command word that travels
// from the front end to the back end through the command queue.
// ----------------------------------------------------------------------------
package skte_pkg;

    // Operation codes on the input channel.
    localparam logic [2:0] OP_SCAN    = 3'd0;
    localparam logic [2:0] OP_QUERY   = 3'd1;
    localparam logic [2:0] OP_CONSUME = 3'd2;
    localparam logic [2:0] OP_POLL    = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    // Scan byte fields and set-1 codes.
    localparam logic [7:0] SC_PREFIX   = 8'hE0;
    localparam logic [6:0] SC_ESC      = 7'h01;
    localparam logic [6:0] SC_ENTER    = 7'h1C;
    localparam logic [6:0] SC_W        = 7'h11;
    localparam logic [6:0] SC_S        = 7'h1F;
    localparam logic [6:0] SC_A_LEFT   = 7'h1E;
    localparam logic [6:0] SC_D_RIGHT  = 7'h20;
    localparam logic [6:0] SC_EX_UP    = 7'h48;
    localparam logic [6:0] SC_EX_DOWN  = 7'h50;
    localparam logic [6:0] SC_EX_LEFT  = 7'h4B;
    localparam logic [6:0] SC_EX_RIGHT = 7'h4D;

    // Number of tracked keys; bit k-1 of a key mask stands for key id k.
    localparam int NUM_KEYS = 8;

    // Key mask bits in key id order.
    localparam logic [NUM_KEYS-1:0] KM_ESC   = 8'b0000_0001;
    localparam logic [NUM_KEYS-1:0] KM_ENTER = 8'b0000_0010;
    localparam logic [NUM_KEYS-1:0] KM_LEFT  = 8'b0000_0100;
    localparam logic [NUM_KEYS-1:0] KM_RIGHT = 8'b0000_1000;
    localparam logic [NUM_KEYS-1:0] KM_UP    = 8'b0001_0000;
    localparam logic [NUM_KEYS-1:0] KM_DOWN  = 8'b0010_0000;
    localparam logic [NUM_KEYS-1:0] KM_W     = 8'b0100_0000;
    localparam logic [NUM_KEYS-1:0] KM_S     = 8'b1000_0000;

    // Depth of the command queue between front and back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [NUM_KEYS-1:0] key_mask_t;

    // Classified command kinds.
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_PRESS,
        CMD_RELEASE,
        CMD_QUERY,
        CMD_CONSUME,
        CMD_POLL,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        key_mask_t key_mask;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

/* rtl/skte_front.sv */
// ----------------------------------------------------------------------------
// skte_front: input classification
// Accepts input items, tracks the extended-prefix flag, translates scan bytes
// and key ids into key masks and pushes one command per item into the queue.
// ----------------------------------------------------------------------------
module skte_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           operation,
    input  logic [7:0]           scan_byte,
    input  logic [3:0]           key_id,
    input  skte_pkg::q_status_t  q_status,
    output logic                 push,
    output skte_pkg::cmd_t       push_cmd
);

    logic                 extended_armed_reg;
    logic                 extended_armed_next;
    skte_pkg::key_mask_t  scan_mask;
    skte_pkg::key_mask_t  id_mask;
    logic [2:0]           id_index;

    assign in_ready = !q_status.full;
    assign push     = in_valid && !q_status.full;

    // Translate the low seven bits of a scan byte, plain or extended.
    always_comb
    begin
        scan_mask = '0;
        if (extended_armed_reg)
        begin
            case (scan_byte[6:0])
                skte_pkg::SC_EX_UP:    scan_mask = skte_pkg::KM_UP;
                skte_pkg::SC_EX_DOWN:  scan_mask = skte_pkg::KM_DOWN;
                skte_pkg::SC_EX_LEFT:  scan_mask = skte_pkg::KM_LEFT;
                skte_pkg::SC_EX_RIGHT: scan_mask = skte_pkg::KM_RIGHT;
                skte_pkg::SC_ENTER:    scan_mask = skte_pkg::KM_ENTER;
                default:               scan_mask = '0;
            endcase
        end
        else
        begin
            case (scan_byte[6:0])
                skte_pkg::SC_ESC:     scan_mask = skte_pkg::KM_ESC;
                skte_pkg::SC_ENTER:   scan_mask = skte_pkg::KM_ENTER;
                skte_pkg::SC_W:       scan_mask = skte_pkg::KM_W;
                skte_pkg::SC_S:       scan_mask = skte_pkg::KM_S;
                skte_pkg::SC_A_LEFT:  scan_mask = skte_pkg::KM_LEFT;
                skte_pkg::SC_D_RIGHT: scan_mask = skte_pkg::KM_RIGHT;
                default:              scan_mask = '0;
            endcase
        end
    end

    // Key ids 1 to 8 select one mask bit; any other id selects none.
    assign id_index = 3'(key_id - 4'd1);

    always_comb
    begin
        if (key_id inside {[4'd1:4'd8]})
        begin
            id_mask = skte_pkg::key_mask_t'(1) << id_index;
        end
        else
        begin
            id_mask = '0;
        end
    end

    // Build the command and the next prefix flag.
    always_comb
    begin
        push_cmd.kind       = skte_pkg::CMD_NOP;
        push_cmd.key_mask   = '0;
        extended_armed_next = extended_armed_reg;
        case (operation)
            skte_pkg::OP_SCAN:
            begin
                if (scan_byte == skte_pkg::SC_PREFIX)
                begin
                    extended_armed_next = 1'b1;
                end
                else
                begin
                    extended_armed_next = 1'b0;
                    push_cmd.key_mask   = scan_mask;
                    if (scan_mask != '0)
                    begin
                        push_cmd.kind = scan_byte[7] ? skte_pkg::CMD_RELEASE
                                                     : skte_pkg::CMD_PRESS;
                    end
                end
            end
            skte_pkg::OP_QUERY:
            begin
                push_cmd.kind     = skte_pkg::CMD_QUERY;
                push_cmd.key_mask = id_mask;
            end
            skte_pkg::OP_CONSUME:
            begin
                push_cmd.kind     = skte_pkg::CMD_CONSUME;
                push_cmd.key_mask = id_mask;
            end
            skte_pkg::OP_POLL:  push_cmd.kind = skte_pkg::CMD_POLL;
            skte_pkg::OP_CLEAR: push_cmd.kind = skte_pkg::CMD_CLEAR;
            default:            push_cmd.kind = skte_pkg::CMD_NOP;
        endcase
    end

    // The prefix flag only moves on an accepted transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extended_armed_reg <= 1'b0;
        end
        else if (push)
        begin
            extended_armed_reg <= extended_armed_next;
        end
    end

endmodule

/* rtl/skte_queue.sv */
// ----------------------------------------------------------------------------
// skte_queue: command queue
// Small first-in first-out buffer of classified commands between the front
// and back ends. Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module skte_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  skte_pkg::cmd_t       push_cmd,
    input  logic                 pop,
    output skte_pkg::cmd_t       pop_cmd,
    output skte_pkg::q_status_t  q_status
);

    localparam int PW = skte_pkg::QPTR_W;
    localparam int CW = skte_pkg::QCNT_W;
    localparam logic [PW-1:0] LAST_PTR = PW'(skte_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(skte_pkg::QUEUE_DEPTH);

    skte_pkg::cmd_t  entry_reg [skte_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == FULL_CNT);
    assign pop_cmd        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/skte_back.sv */
// ----------------------------------------------------------------------------
// skte_back: command execution
// Holds the held and pending key masks, carries out one command per cycle
// while the output register can accept it, and holds results until taken.
// ----------------------------------------------------------------------------
module skte_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  skte_pkg::q_status_t  q_status,
    input  skte_pkg::cmd_t       pop_cmd,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 answer_flag,
    output logic [3:0]           polled_key
);

    skte_pkg::key_mask_t  held_reg;
    skte_pkg::key_mask_t  held_next;
    skte_pkg::key_mask_t  pending_reg;
    skte_pkg::key_mask_t  pending_next;
    skte_pkg::key_mask_t  low_bit;
    logic                 out_valid_reg;
    logic                 answer_reg;
    logic                 answer_next;
    logic [3:0]           polled_reg;
    logic [3:0]           polled_next;
    logic [3:0]           low_code;

    assign out_valid   = out_valid_reg;
    assign answer_flag = answer_reg;
    assign polled_key  = polled_reg;

    // Take a command when the output register is free or being emptied.
    assign pop = !q_status.empty && (!out_valid_reg || out_ready);

    // Lowest pending key and its key id.
    assign low_bit = pending_reg & (~pending_reg + skte_pkg::key_mask_t'(1));

    always_comb
    begin
        low_code = 4'd0;
        for (int i = 0; i < skte_pkg::NUM_KEYS; i++)
        begin
            if (low_bit[i])
            begin
                low_code = 4'(i + 1);
            end
        end
    end

    // Execute the command at the head of the queue.
    always_comb
    begin
        held_next    = held_reg;
        pending_next = pending_reg;
        answer_next  = 1'b0;
        polled_next  = 4'd0;
        case (pop_cmd.kind)
            skte_pkg::CMD_PRESS:
            begin
                pending_next = pending_reg | (pop_cmd.key_mask & ~held_reg);
                held_next    = held_reg | pop_cmd.key_mask;
            end
            skte_pkg::CMD_RELEASE:
            begin
                held_next = held_reg & ~pop_cmd.key_mask;
            end
            skte_pkg::CMD_QUERY:
            begin
                answer_next = |(held_reg & pop_cmd.key_mask);
            end
            skte_pkg::CMD_CONSUME:
            begin
                answer_next  = |(pending_reg & pop_cmd.key_mask);
                pending_next = pending_reg & ~pop_cmd.key_mask;
            end
            skte_pkg::CMD_POLL:
            begin
                polled_next  = low_code;
                pending_next = pending_reg & ~low_bit;
            end
            skte_pkg::CMD_CLEAR:
            begin
                pending_next = '0;
            end
            default:
            begin
                answer_next = 1'b0;
            end
        endcase
    end

    // Key state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                held_reg      <= held_next;
                pending_reg   <= pending_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            answer_reg <= answer_next;
            polled_reg <= polled_next;
        end
    end

endmodule

/* rtl/scancode_key_event_tracker_core.sv */
// ----------------------------------------------------------------------------
// scancode_key_event_tracker_core: set-1 scan-code key event tracker
// Tracks held and one-shot pressed state of eight control keys.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries operation, scan_byte and key_id.
//   Operation 0 feeds a raw scan byte, 1 queries a held key, 2 consumes a
//   press, 3 polls and clears the first pending press, 4 clears all presses.
//   Output channel (out_valid/out_ready) returns one result per input
//   transfer: answer_flag and polled_key, in input order.
//   Each input passes through the command queue and is then registered in
//   the output register, where its result is presented.
//   Throughput: one item per cycle while the receiver takes results, set by
//   the key-state update in the back end; the front end classifies an item
//   in the cycle it arrives and hands it over through a two-entry command queue.
//   When the receiver stalls, the output register holds its result, the
//   queue fills and in_ready drops once it holds two commands.
//   Reset clears the extended-prefix flag, both key masks, the queue and the
//   output valid; the block accepts items as soon as reset is released.
// ----------------------------------------------------------------------------
module scancode_key_event_tracker_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [7:0]  scan_byte,
    input  logic [3:0]  key_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        answer_flag,
    output logic [3:0]  polled_key
);

    skte_pkg::q_status_t  q_status;
    skte_pkg::cmd_t       push_cmd;
    skte_pkg::cmd_t       pop_cmd;
    logic                 push;
    logic                 pop;

    // Front end: accept and classify.
    skte_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .scan_byte (scan_byte),
        .key_id    (key_id),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Command queue between the two ends.
    skte_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    // Back end: execute and present results.
    skte_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .pop_cmd     (pop_cmd),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .answer_flag (answer_flag),
        .polled_key  (polled_key)
    );

    // A queue can never be empty and full at once.
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.empty && q_status.full))
        else $error("command queue reports empty and full together");

    // A result never carries both an answer and a polled key.
    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(answer_flag && (polled_key != 4'd0)))
        else $error("result has both answer_flag and polled_key set");

    // A polled key is always a valid key id or zero.
    a_polled_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (polled_key <= 4'd8))
        else $error("polled_key out of range");

    // A pop only happens while the queue holds a command.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("command popped from an empty queue");

endmodule

/* verif/tb_scancode_key_event_tracker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scancode_key_event_tracker_core: testbench for the key event tracker
// Drives scan bytes and key operations through the input channel and checks
// every answer against a cycle-free model of the held and pressed key masks.
// Both channels idle at random, and directed, random, fill and drain phases
// run in turn from one initial block.
// ----------------------------------------------------------------------------
module tb_scancode_key_event_tracker_core;

    // Key ids as seen on key_id and polled_key.
    localparam logic [3:0] KID_NONE  = 4'd0;
    localparam logic [3:0] KID_ESC   = 4'd1;
    localparam logic [3:0] KID_ENTER = 4'd2;
    localparam logic [3:0] KID_LEFT  = 4'd3;
    localparam logic [3:0] KID_RIGHT = 4'd4;
    localparam logic [3:0] KID_UP    = 4'd5;
    localparam logic [3:0] KID_DOWN  = 4'd6;
    localparam logic [3:0] KID_W     = 4'd7;
    localparam logic [3:0] KID_S     = 4'd8;
    localparam logic [3:0] KID_MAX   = 4'd15;

    // Operation codes past the defined set, and scan bytes that map to nothing.
    localparam logic [2:0] OP_LAST        = 3'd7;
    localparam logic [7:0] SC_ALL_ZERO    = 8'h00;
    localparam logic [7:0] SC_ALL_ONE     = 8'hFF;
    localparam logic [6:0] SC_UNUSED      = 7'h30;
    localparam int         NUM_STROKES    = 11;

    localparam int HOLD_OFF_CYCLES = 48;
    localparam int IDLE_LIMIT      = 1000;
    localparam int TAIL_CYCLES     = 4;
    localparam int RANDOM_ITEMS    = 530;

    typedef struct packed {
        logic       answer_flag;
        logic [3:0] polled_key;
    } key_answer_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [2:0] operation   = skte_pkg::OP_SCAN;
    logic [7:0] scan_byte   = 8'h00;
    logic [3:0] key_id      = KID_NONE;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic       answer_flag;
    logic [3:0] polled_key;

    // Model state of the tracker.
    logic                          prefix_armed = 1'b0;
    logic [skte_pkg::NUM_KEYS-1:0] keys_held    = '0;
    logic [skte_pkg::NUM_KEYS-1:0] keys_pending = '0;

    key_answer_t answer_q[$];

    int unsigned items_sent      = 0;
    int unsigned answers_checked = 0;
    int unsigned fail_count      = 0;
    int unsigned mismatch_count  = 0;
    int unsigned polls_with_key  = 0;
    int unsigned presses_taken   = 0;
    int unsigned burst_left      = 0;
    int unsigned hold_offs_done  = 0;
    bit          hold_off_request = 1'b0;

    scancode_key_event_tracker_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .scan_byte   (scan_byte),
        .key_id      (key_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .answer_flag (answer_flag),
        .polled_key  (polled_key)
    );

    always #2 clk = ~clk;

    // Applies one operation to the model masks and returns the answer it gives.
    function automatic key_answer_t next_key_answer(input logic [2:0] op,
                                                    input logic [7:0] sb,
                                                    input logic [3:0] kid);
        key_answer_t                   ans;
        logic [3:0]                    k;
        logic [2:0]                    kidx;
        logic [skte_pkg::NUM_KEYS-1:0] kbit;
        bit                            found;
        ans   = '0;
        k     = KID_NONE;
        kidx  = 3'(kid - KID_ESC);
        found = 1'b0;
        case (op)
            skte_pkg::OP_SCAN:
            begin
                if (sb == skte_pkg::SC_PREFIX)
                begin
                    prefix_armed = 1'b1;
                end
                else
                begin
                    if (prefix_armed)
                    begin
                        case (sb[6:0])
                            skte_pkg::SC_EX_UP:    k = KID_UP;
                            skte_pkg::SC_EX_DOWN:  k = KID_DOWN;
                            skte_pkg::SC_EX_LEFT:  k = KID_LEFT;
                            skte_pkg::SC_EX_RIGHT: k = KID_RIGHT;
                            skte_pkg::SC_ENTER:    k = KID_ENTER;
                            default:               k = KID_NONE;
                        endcase
                    end
                    else
                    begin
                        case (sb[6:0])
                            skte_pkg::SC_ESC:      k = KID_ESC;
                            skte_pkg::SC_ENTER:    k = KID_ENTER;
                            skte_pkg::SC_W:        k = KID_W;
                            skte_pkg::SC_S:        k = KID_S;
                            skte_pkg::SC_A_LEFT:   k = KID_LEFT;
                            skte_pkg::SC_D_RIGHT:  k = KID_RIGHT;
                            default:               k = KID_NONE;
                        endcase
                    end
                    prefix_armed = 1'b0;
                    if (k != KID_NONE)
                    begin
                        kbit = skte_pkg::KM_ESC << (k - KID_ESC);
                        if (sb[7])
                        begin
                            keys_held = keys_held & ~kbit;
                        end
                        else
                        begin
                            // Only a fresh press arms the one-shot flag.
                            if ((keys_held & kbit) == '0)
                                keys_pending = keys_pending | kbit;
                            keys_held = keys_held | kbit;
                        end
                    end
                end
            end
            skte_pkg::OP_QUERY:
            begin
                if (kid >= KID_ESC && kid <= KID_S)
                    ans.answer_flag = keys_held[kidx];
            end
            skte_pkg::OP_CONSUME:
            begin
                if (kid >= KID_ESC && kid <= KID_S && keys_pending[kidx])
                begin
                    keys_pending[kidx] = 1'b0;
                    ans.answer_flag = 1'b1;
                end
            end
            skte_pkg::OP_POLL:
            begin
                // Lowest key id wins; only that one is cleared.
                for (int i = 0; i < skte_pkg::NUM_KEYS; i++)
                begin
                    if (!found && keys_pending[i])
                    begin
                        keys_pending[i] = 1'b0;
                        ans.polled_key  = KID_ESC + 4'(i);
                        found = 1'b1;
                    end
                end
            end
            skte_pkg::OP_CLEAR:
            begin
                keys_pending = '0;
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    // Offers one item, waits for its transfer and records the expected answer.
    task automatic issue_key_op(input logic [2:0] op, input logic [7:0] sb,
                                input logic [3:0] kid);
        int unsigned gap;
        key_answer_t want;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        operation <= op;
        scan_byte <= sb;
        key_id    <= kid;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        want = next_key_answer(op, sb, kid);
        if (op == skte_pkg::OP_POLL && want.polled_key != KID_NONE)
            polls_with_key++;
        if (op == skte_pkg::OP_CONSUME && want.answer_flag)
            presses_taken++;
        answer_q.push_back(want);
        items_sent++;
    endtask

    // Stops offering and waits until every expected answer has come back.
    task automatic wait_answers_drained();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (answer_q.size() != 0)
            @(posedge clk);
    endtask

    // Mostly a tracked key id, now and then any four-bit value.
    function automatic logic [3:0] pick_key_id();
        if ($urandom_range(0, 7) == 0)
            return 4'($urandom_range(0, KID_MAX));
        return 4'($urandom_range(KID_ESC, KID_S));
    endfunction

    // Sends the scan bytes of one press or release of a tracked key.
    task automatic send_key_stroke(input int unsigned which, input logic is_release);
        logic       ext;
        logic [6:0] code;
        ext = 1'b0;
        case (which)
            0:       code = skte_pkg::SC_ESC;
            1:       code = skte_pkg::SC_ENTER;
            2:       code = skte_pkg::SC_W;
            3:       code = skte_pkg::SC_S;
            4:       code = skte_pkg::SC_A_LEFT;
            5:       code = skte_pkg::SC_D_RIGHT;
            6:       begin ext = 1'b1; code = skte_pkg::SC_EX_UP;    end
            7:       begin ext = 1'b1; code = skte_pkg::SC_EX_DOWN;  end
            8:       begin ext = 1'b1; code = skte_pkg::SC_EX_LEFT;  end
            9:       begin ext = 1'b1; code = skte_pkg::SC_EX_RIGHT; end
            default: begin ext = 1'b1; code = skte_pkg::SC_ENTER;    end
        endcase
        if (ext)
            issue_key_op(skte_pkg::OP_SCAN, skte_pkg::SC_PREFIX,
                         4'($urandom_range(0, KID_MAX)));
        issue_key_op(skte_pkg::OP_SCAN, {is_release, code}, 4'($urandom_range(0, KID_MAX)));
    endtask

    // Field extremes, prefix handling and every operation with known answers.
    task automatic test_directed_cases();
        issue_key_op(skte_pkg::OP_SCAN, SC_ALL_ZERO, KID_MAX);
        issue_key_op(skte_pkg::OP_SCAN, SC_ALL_ONE, KID_NONE);
        // A doubled prefix still arms only the next byte.
        issue_key_op(skte_pkg::OP_SCAN, skte_pkg::SC_PREFIX, KID_NONE);
        issue_key_op(skte_pkg::OP_SCAN, skte_pkg::SC_PREFIX, KID_NONE);
        issue_key_op(skte_pkg::OP_SCAN, {1'b0, skte_pkg::SC_EX_UP}, KID_NONE);
        // An unknown byte after the prefix disarms it, so down is not pressed.
        issue_key_op(skte_pkg::OP_SCAN, skte_pkg::SC_PREFIX, KID_NONE);
        issue_key_op(skte_pkg::OP_SCAN, {1'b0, SC_UNUSED}, KID_NONE);
        issue_key_op(skte_pkg::OP_SCAN, {1'b0, skte_pkg::SC_EX_DOWN}, KID_NONE);
        // Press, repeat and release escape; the press stays pending.
        issue_key_op(skte_pkg::OP_SCAN, {1'b0, skte_pkg::SC_ESC}, KID_NONE);
        issue_key_op(skte_pkg::OP_SCAN, {1'b0, skte_pkg::SC_ESC}, KID_NONE);
        issue_key_op(skte_pkg::OP_SCAN, {1'b1, skte_pkg::SC_ESC}, KID_NONE);
        issue_key_op(skte_pkg::OP_QUERY, SC_ALL_ONE, KID_ESC);
        issue_key_op(skte_pkg::OP_QUERY, SC_ALL_ZERO, KID_UP);
        issue_key_op(skte_pkg::OP_QUERY, SC_ALL_ZERO, KID_DOWN);
        issue_key_op(skte_pkg::OP_QUERY, SC_ALL_ZERO, KID_NONE);
        issue_key_op(skte_pkg::OP_CONSUME, SC_ALL_ZERO, KID_MAX);
        // Enter plain, then enter extended while held: one pending press.
        issue_key_op(skte_pkg::OP_SCAN, {1'b0, skte_pkg::SC_ENTER}, KID_NONE);
        issue_key_op(skte_pkg::OP_SCAN, skte_pkg::SC_PREFIX, KID_NONE);
        issue_key_op(skte_pkg::OP_SCAN, {1'b0, skte_pkg::SC_ENTER}, KID_NONE);
        issue_key_op(skte_pkg::OP_POLL, SC_ALL_ZERO, KID_NONE);
        issue_key_op(skte_pkg::OP_POLL, SC_ALL_ZERO, KID_NONE);
        issue_key_op(skte_pkg::OP_CONSUME, SC_ALL_ZERO, KID_UP);
        issue_key_op(skte_pkg::OP_POLL, SC_ALL_ZERO, KID_NONE);
        // Clearing presses keeps the held state.
        issue_key_op(skte_pkg::OP_SCAN, {1'b0, skte_pkg::SC_S}, KID_NONE);
        issue_key_op(skte_pkg::OP_CLEAR, SC_ALL_ZERO, KID_S);
        issue_key_op(skte_pkg::OP_QUERY, SC_ALL_ZERO, KID_S);
        for (int op = skte_pkg::OP_CLEAR + 1; op <= OP_LAST; op++)
            issue_key_op(3'(op), SC_ALL_ONE, KID_MAX);
        wait_answers_drained();
    endtask

    // Key strokes with random content, queries and polls, plus some noise.
    task automatic test_random_traffic();
        int unsigned pick;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_key_stroke($urandom_range(0, NUM_STROKES - 1), $urandom_range(0, 9) < 4);
            else if (pick < 60)
                issue_key_op(skte_pkg::OP_QUERY, 8'($urandom_range(0, 255)), pick_key_id());
            else if (pick < 72)
                issue_key_op(skte_pkg::OP_CONSUME, 8'($urandom_range(0, 255)), pick_key_id());
            else if (pick < 84)
                issue_key_op(skte_pkg::OP_POLL, 8'($urandom_range(0, 255)),
                             4'($urandom_range(0, KID_MAX)));
            else if (pick < 88)
                issue_key_op(skte_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                             4'($urandom_range(0, KID_MAX)));
            else
                issue_key_op(3'($urandom_range(0, OP_LAST)), 8'($urandom_range(0, 255)),
                             4'($urandom_range(0, KID_MAX)));
            if (n % 150 == 149)
                wait_answers_drained();
        end
        wait_answers_drained();
    endtask

    // The receiver holds off while items keep coming, so the block fills up.
    task automatic test_fill_and_drain();
        hold_off_request = 1'b1;
        burst_left = 40;
        for (int n = 0; n < 20; n++)
            send_key_stroke($urandom_range(0, NUM_STROKES - 1), 1'($urandom_range(0, 1)));
        wait_answers_drained();
        for (int n = 0; n < 12; n++)
            issue_key_op(skte_pkg::OP_POLL, 8'($urandom_range(0, 255)),
                         4'($urandom_range(0, KID_MAX)));
        wait_answers_drained();
    endtask

    // Receiver: rotating ready patterns, and a long hold-off when asked.
    initial
    begin : receiver
        logic [7:0]  stall_pattern;
        int unsigned pattern_left;
        int unsigned phase;
        stall_pattern = '1;
        pattern_left  = 0;
        phase         = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                out_ready <= 1'b0;
                for (int c = 0; c < HOLD_OFF_CYCLES; c++)
                    @(posedge clk);
                hold_offs_done++;
            end
            if (pattern_left == 0)
            begin
                stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF
                                                             : 8'($urandom_range(1, 255));
                pattern_left  = 32;
            end
            pattern_left--;
            phase = (phase + 1) % 8;
            out_ready <= stall_pattern[phase];
        end
    end

    // Each transfer on the output is checked against the oldest expectation.
    always @(posedge clk)
    begin : answer_check
        key_answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            answers_checked++;
            if (answer_q.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected answer flag=%0b key=%0d", $realtime,
                             answer_flag, polled_key);
            end
            else
            begin
                want = answer_q.pop_front();
                if (answer_flag !== want.answer_flag || polled_key !== want.polled_key)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch: want flag=%0b key=%0d, got flag=%0b key=%0d",
                                 $realtime, want.answer_flag, want.polled_key,
                                 answer_flag, polled_key);
                end
            end
        end
    end

    // Ends the run when nothing has been transferred for too long.
    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer in %0d cycles, %0d answers outstanding",
                         IDLE_LIMIT, answer_q.size());
                $display("tb_scancode_key_event_tracker_core failed");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_traffic();
        test_fill_and_drain();
        wait_answers_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (answer_q.size() != 0)
            fail_count++;
        $display("Sent %0d items, checked %0d answers, %0d mismatches.",
                 items_sent, answers_checked, mismatch_count);
        $display("Polls that found a key: %0d, presses consumed: %0d, receiver hold-offs: %0d.",
                 polls_with_key, presses_taken, hold_offs_done);
        if (fail_count == 0)
            $display("tb_scancode_key_event_tracker_core passed");
        else
            $display("tb_scancode_key_event_tracker_core failed");
        $finish;
    end

endmodule
